// ===== sv/nmgga_pkg.sv =====
// ---------------------------------------------------------------------------
// nmgga_pkg
// Shared constants, character codes, field indexes and the event record
// passed from the byte parser to the conversion pipeline.
// ---------------------------------------------------------------------------
package nmgga_pkg;

  localparam int MAX_LEN         = 128;
  localparam int MIN_FRAC_DIGITS = 5;

  // accumulator widths
  localparam int ACC_W  = 20;
  localparam int CNT_W  = 8;

  // characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_US     = 8'h53;
  localparam logic [7:0] CH_UW     = 8'h57;

  localparam int HDR_LEN = 5;

  // field indexes
  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] FLD_FIX  = 4'd6;
  localparam logic [3:0] FLD_SATS = 4'd7;
  localparam logic [3:0] FLD_HDOP = 4'd8;
  localparam logic [3:0] FLD_LAST = 4'd15;

  // saturation limits
  localparam logic [ACC_W-1:0] INT_CEIL  = ACC_W'(999999);
  localparam logic [26:0]      LAT_CEIL  = 27'd99999999;
  localparam logic [29:0]      LON_CEIL  = 30'd999999999;
  localparam logic [13:0]      HDOP_CEIL = 14'd9999;
  localparam logic [6:0]       SAT_CEIL  = 7'd99;

  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    unique case (n)
      0:       r = 64'd1;
      1:       r = 64'd10;
      2:       r = 64'd100;
      3:       r = 64'd1000;
      4:       r = 64'd10000;
      5:       r = 64'd100000;
      6:       r = 64'd1000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h47;  // G
      3'd1:    r = 8'h4E;  // N
      3'd2:    r = 8'h47;  // G
      3'd3:    r = 8'h47;  // G
      3'd4:    r = 8'h41;  // A
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // reciprocal constants for division by constants
  localparam longint unsigned D_MS  = pow10(MIN_FRAC_DIGITS - 3);
  localparam longint unsigned D_HD  = pow10(MIN_FRAC_DIGITS - 2);
  localparam longint unsigned NUM_M = pow10(6 - MIN_FRAC_DIGITS);
  localparam logic [31:0] M100 = 32'(((64'd1 << 32) + 64'd99) / 64'd100);
  localparam logic [35:0] M_MS = 36'(((64'd1 << 36) + D_MS - 64'd1) / D_MS);
  localparam logic [35:0] M_HD = 36'(((64'd1 << 36) + D_HD - 64'd1) / D_HD);
  localparam logic [28:0] M60  = 29'(((64'd1 << 34) + 64'd59) / 64'd60);

  typedef struct packed {
    logic             fld;    // field closes
    logic             emt;    // sentence ends, emit
    logic             clr;    // sentence start, clear held values
    logic [3:0]       idx;
    logic             ok;
    logic             fix;
    logic             south;
    logic             west;
    logic [ACC_W-1:0] w;      // integer part
    logic [ACC_W-1:0] fs;     // fraction scaled to MIN_FRAC_DIGITS digits
  } ev_t;

endpackage

// ===== sv/nmea_gga_sentence_parser.sv =====
// ---------------------------------------------------------------------------
// nmea_gga_sentence_parser
// GNGGA sentence decoder producing one result record per sentence.
// ---------------------------------------------------------------------------
// Takes one receiver byte per cycle on the input stream and never stalls
// while the result register is free. A '$' opens a sentence; each line
// feed inside a sentence yields one result, which passes through the parser
// register, five conversion stages and the result register. Numeric field
// conversion (divide by 100, minutes to microdegrees through a reciprocal
// multiply by 1/60) runs in that pipeline, with the constant multiplies
// spread over the stages. Input is held off only while a finished result
// sits in the output register unaccepted and a second result reaches the
// end of the pipeline.
module nmea_gga_sentence_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,    // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] sentence_ok, [1] fix_valid, [8:2] utc_hour, [15:9] utc_minute,
  // [22:16] utc_second, [32:23] utc_millis, [59:33] lat_microdeg,
  // [60] lat_south, [90:61] lon_microdeg, [91] lon_west,
  // [98:92] satellites, [112:99] hdop_centi, rest zero
  output logic [119:0] m_tdata
);

  logic           adv;
  nmgga_pkg::ev_t pev;

  assign s_tready = adv;

  // byte parser: one transfer per cycle while input is not held off
  nmgga_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (s_tvalid && adv),
    .c    (s_tdata),
    .adv  (adv),
    .ev   (pev)
  );

  // field conversion and result register
  nmgga_conv u_conv (
    .clk      (clk),
    .rst      (rst),
    .pev      (pev),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== sv/nmgga_parser.sv =====
// ---------------------------------------------------------------------------
// nmgga_parser
// Byte-level sentence parser: checksum, header, field split, accumulators.
// ---------------------------------------------------------------------------
module nmgga_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       c,
  input  logic             adv,
  output nmgga_pkg::ev_t   ev
);

  logic                          in_sentence, in_sentence_next;
  logic [nmgga_pkg::CNT_W-1:0]   char_count, char_count_next;
  logic [7:0]                    xor_acc, xor_acc_next;
  logic                          header_match, header_match_next;
  logic [3:0]                    field_index, field_index_next;
  logic [1:0]                    star_phase, star_phase_next;
  logic [7:0]                    rx_checksum, rx_checksum_next;
  logic [nmgga_pkg::ACC_W-1:0]   int_accum, int_accum_next;
  logic [nmgga_pkg::ACC_W-1:0]   frac_accum, frac_accum_next;
  logic [2:0]                    frac_digits, frac_digits_next;
  logic                          fix_flag, fix_flag_next;
  logic                          south, south_next;
  logic                          west, west_next;
  logic                          hex_err, hex_err_next;
  nmgga_pkg::ev_t                ev_next;

  logic [2:0]                    kept;
  logic [nmgga_pkg::ACC_W-1:0]   fs;
  logic [23:0]                   int_x10;
  logic [3:0]                    digit, hexv;
  logic                          is_digit, is_hex;

  always_comb begin
    kept = (frac_digits == 3'd0) ? 3'd0 : frac_digits - 3'd1;
    if (kept > 3'(nmgga_pkg::MIN_FRAC_DIGITS)) kept = 3'(nmgga_pkg::MIN_FRAC_DIGITS);
    fs = nmgga_pkg::ACC_W'(frac_accum *
         nmgga_pkg::ACC_W'(nmgga_pkg::pow10(nmgga_pkg::MIN_FRAC_DIGITS - int'(kept))));
  end

  assign is_digit = (c >= nmgga_pkg::CH_0) && (c <= nmgga_pkg::CH_9);
  assign digit    = 4'(c - nmgga_pkg::CH_0);
  assign is_hex   = (c >= nmgga_pkg::CH_UA) && (c <= nmgga_pkg::CH_UF);
  assign hexv     = 4'(c - nmgga_pkg::CH_UA + 8'd10);
  assign int_x10  = 24'(int_accum) * 24'd10 + 24'(digit);

  always_comb begin
    in_sentence_next  = in_sentence;
    char_count_next   = char_count;
    xor_acc_next      = xor_acc;
    header_match_next = header_match;
    field_index_next  = field_index;
    star_phase_next   = star_phase;
    rx_checksum_next  = rx_checksum;
    int_accum_next    = int_accum;
    frac_accum_next   = frac_accum;
    frac_digits_next  = frac_digits;
    fix_flag_next     = fix_flag;
    south_next        = south;
    west_next         = west;
    hex_err_next      = hex_err;
    ev_next           = '0;
    ev_next.idx       = field_index;
    ev_next.w         = int_accum;
    ev_next.fs        = fs;

    if (take) begin
      if (c == nmgga_pkg::CH_DOLLAR) begin
        in_sentence_next  = 1'b1;
        char_count_next   = '0;
        xor_acc_next      = '0;
        header_match_next = 1'b1;
        field_index_next  = '0;
        star_phase_next   = '0;
        rx_checksum_next  = '0;
        int_accum_next    = '0;
        frac_accum_next   = '0;
        frac_digits_next  = '0;
        fix_flag_next     = 1'b0;
        south_next        = 1'b0;
        west_next         = 1'b0;
        hex_err_next      = 1'b0;
        ev_next.clr       = 1'b1;
      end else if (in_sentence) begin
        if (char_count >= nmgga_pkg::CNT_W'(nmgga_pkg::MAX_LEN)) begin
          in_sentence_next = 1'b0;   // overlong: drop
        end else begin
          char_count_next = char_count + 1'b1;
          if (c == nmgga_pkg::CH_LF) begin
            ev_next.emt = 1'b1;
            ev_next.fld = (star_phase == 2'd0);
            ev_next.ok  = header_match && (char_count >= nmgga_pkg::CNT_W'(nmgga_pkg::HDR_LEN))
                          && (star_phase == 2'd3) && !hex_err && (rx_checksum == xor_acc);
            ev_next.fix   = ev_next.ok && fix_flag;
            ev_next.south = south;
            ev_next.west  = west;
            in_sentence_next = 1'b0;
          end else begin
            if (char_count < nmgga_pkg::CNT_W'(nmgga_pkg::HDR_LEN) &&
                c != nmgga_pkg::hdr_char(char_count[2:0]))
              header_match_next = 1'b0;
            if (star_phase == 2'd0) begin
              if (c == nmgga_pkg::CH_STAR || c == nmgga_pkg::CH_COMMA) begin
                if (c == nmgga_pkg::CH_STAR) star_phase_next = 2'd1;
                else xor_acc_next = xor_acc ^ c;
                ev_next.fld      = 1'b1;
                field_index_next = (field_index != nmgga_pkg::FLD_LAST) ?
                                   field_index + 4'd1 : field_index;
                int_accum_next   = '0;
                frac_accum_next  = '0;
                frac_digits_next = '0;
              end else begin
                xor_acc_next = xor_acc ^ c;
                if (field_index == nmgga_pkg::FLD_NS || field_index == nmgga_pkg::FLD_EW ||
                    field_index == nmgga_pkg::FLD_FIX) begin
                  if (int_accum == '0) begin
                    int_accum_next = nmgga_pkg::ACC_W'(1);
                    if (field_index == nmgga_pkg::FLD_FIX) fix_flag_next = (c >= nmgga_pkg::CH_1);
                    else if (field_index == nmgga_pkg::FLD_NS) south_next = (c == nmgga_pkg::CH_US);
                    else west_next = (c == nmgga_pkg::CH_UW);
                  end
                end else if (is_digit) begin
                  if (frac_digits == 3'd0) begin
                    int_accum_next = (int_x10 > 24'(nmgga_pkg::INT_CEIL)) ?
                                     nmgga_pkg::INT_CEIL : nmgga_pkg::ACC_W'(int_x10);
                  end else if (frac_digits <= 3'(nmgga_pkg::MIN_FRAC_DIGITS)) begin
                    frac_accum_next  = nmgga_pkg::ACC_W'(frac_accum * 10 + nmgga_pkg::ACC_W'(digit));
                    frac_digits_next = frac_digits + 3'd1;
                  end
                end else if (c == nmgga_pkg::CH_DOT && frac_digits == 3'd0) begin
                  frac_digits_next = 3'd1;
                end
              end
            end else if (star_phase != 2'd3) begin
              if (is_digit)    rx_checksum_next = {rx_checksum[3:0], digit};
              else if (is_hex) rx_checksum_next = {rx_checksum[3:0], hexv};
              else begin
                rx_checksum_next = {rx_checksum[3:0], 4'd0};
                hex_err_next     = 1'b1;
              end
              star_phase_next = star_phase + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence  <= 1'b0;
      char_count   <= '0;
      xor_acc      <= '0;
      header_match <= 1'b1;
      field_index  <= '0;
      star_phase   <= '0;
      rx_checksum  <= '0;
      int_accum    <= '0;
      frac_accum   <= '0;
      frac_digits  <= '0;
      fix_flag     <= 1'b0;
      south        <= 1'b0;
      west         <= 1'b0;
      hex_err      <= 1'b0;
      ev           <= '0;
    end else begin
      in_sentence  <= in_sentence_next;
      char_count   <= char_count_next;
      xor_acc      <= xor_acc_next;
      header_match <= header_match_next;
      field_index  <= field_index_next;
      star_phase   <= star_phase_next;
      rx_checksum  <= rx_checksum_next;
      int_accum    <= int_accum_next;
      frac_accum   <= frac_accum_next;
      frac_digits  <= frac_digits_next;
      fix_flag     <= fix_flag_next;
      south        <= south_next;
      west         <= west_next;
      hex_err      <= hex_err_next;
      if (adv) ev  <= ev_next;
    end
  end

endmodule

// ===== sv/nmgga_conv.sv =====
// ---------------------------------------------------------------------------
// nmgga_conv
// Field conversion pipeline, held field values and the result register.
// ---------------------------------------------------------------------------
module nmgga_conv (
  input  logic             clk,
  input  logic             rst,
  input  nmgga_pkg::ev_t   pev,
  output logic             adv,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [119:0]     m_tdata
);

  nmgga_pkg::ev_t e1, e2, e3, e4, e5;

  // stage 1
  logic [13:0] q1;
  logic [9:0]  ms1;
  logic [6:0]  hd1;
  logic [51:0] p100;
  logic [55:0] pms, phd;
  // stage 2
  logic [6:0]  r2, hh2, sats2;
  logic [13:0] qk2;
  logic [33:0] deg2;
  logic [26:0] hdop2;
  logic [45:0] pq;
  // stage 3
  logic [6:0]  ss3, mm3, hh3, sats3;
  logic [13:0] hdop3;
  logic [33:0] deg3;
  logic [26:0] mx3;
  // stage 4
  logic [6:0]  ss4, mm4, hh4, sats4;
  logic [13:0] hdop4;
  logic [33:0] deg4;
  logic [20:0] d4;
  logic [55:0] p60;
  // stage 5
  logic [6:0]  ss5, mm5, hh5, sats5;
  logic [13:0] hdop5;
  logic [34:0] v5;
  // held values
  logic [6:0]  h_hour, h_min, h_sec, h_sats;
  logic [9:0]  h_ms, ms4w, ms5w;
  logic [13:0] h_hdop;
  logic [26:0] h_lat;
  logic [29:0] h_lon;
  logic [6:0]  n_hour, n_min, n_sec, n_sats;
  logic [9:0]  n_ms;
  logic [13:0] n_hdop;
  logic [26:0] n_lat;
  logic [29:0] n_lon;

  assign adv = !(e5.emt && m_tvalid && !m_tready);

  assign p100 = 52'(pev.w) * 52'(nmgga_pkg::M100);
  assign pms  = 56'(pev.fs) * 56'(nmgga_pkg::M_MS);
  assign phd  = 56'(pev.fs) * 56'(nmgga_pkg::M_HD);
  assign pq   = 46'(q1) * 46'(nmgga_pkg::M100);
  assign p60  = 56'(mx3) * 56'(nmgga_pkg::M60);

  // milliseconds carried in separate 10-bit registers
  logic [9:0] ms2w, ms3w;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1 <= '0; e2 <= '0; e3 <= '0; e4 <= '0; e5 <= '0;
    end else if (adv) begin
      e1 <= pev; e2 <= e1; e3 <= e2; e4 <= e3; e5 <= e4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: w / 100 and fraction truncations
      q1    <= p100[45:32];
      ms1   <= pms[45:36];
      hd1   <= phd[42:36];
      // stage 2
      r2    <= 7'(e1.w - 20'(q1) * 20'd100);
      hh2   <= pq[38:32];
      qk2   <= q1;
      deg2  <= 34'(q1) * 34'd1000000;
      hdop2 <= 27'(e1.w) * 27'd100 + 27'(hd1);
      sats2 <= (e1.w > 20'(nmgga_pkg::SAT_CEIL)) ? nmgga_pkg::SAT_CEIL : 7'(e1.w);
      ms2w  <= ms1;
      // stage 3
      mx3   <= 27'(r2) * 27'd1000000 + 27'(e2.fs) * 27'(nmgga_pkg::NUM_M);
      mm3   <= 7'(qk2 - 14'(hh2) * 14'd100);
      ss3   <= r2;
      hh3   <= hh2;
      deg3  <= deg2;
      hdop3 <= (hdop2 > 27'(nmgga_pkg::HDOP_CEIL)) ? nmgga_pkg::HDOP_CEIL : 14'(hdop2);
      sats3 <= sats2;
      ms3w  <= ms2w;
      // stage 4: minutes scaled to microdegrees
      d4    <= p60[54:34];
      ss4   <= ss3; mm4 <= mm3; hh4 <= hh3;
      deg4  <= deg3; hdop4 <= hdop3; sats4 <= sats3; ms4w <= ms3w;
      // stage 5
      v5    <= 35'(deg4) + 35'(d4);
      ss5   <= ss4; mm5 <= mm4; hh5 <= hh4;
      hdop5 <= hdop4; sats5 <= sats4; ms5w <= ms4w;
    end
  end

  // merge the closing field into the held values, or clear them at sentence start
  always_comb begin
    n_hour = h_hour; n_min = h_min; n_sec = h_sec; n_ms = h_ms;
    n_sats = h_sats; n_hdop = h_hdop; n_lat = h_lat; n_lon = h_lon;
    if (e5.clr) begin
      n_hour = '0; n_min = '0; n_sec = '0; n_ms = '0;
      n_sats = '0; n_hdop = '0; n_lat = '0; n_lon = '0;
    end else if (e5.fld) begin
      unique case (e5.idx)
        nmgga_pkg::FLD_TIME: begin
          n_hour = hh5; n_min = mm5; n_sec = ss5; n_ms = ms5w;
        end
        nmgga_pkg::FLD_LAT:
          n_lat = (v5 > 35'(nmgga_pkg::LAT_CEIL)) ? nmgga_pkg::LAT_CEIL : 27'(v5);
        nmgga_pkg::FLD_LON:
          n_lon = (v5 > 35'(nmgga_pkg::LON_CEIL)) ? nmgga_pkg::LON_CEIL : 30'(v5);
        nmgga_pkg::FLD_SATS: n_sats = sats5;
        nmgga_pkg::FLD_HDOP: n_hdop = hdop5;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_hour <= '0; h_min <= '0; h_sec <= '0; h_ms <= '0;
      h_sats <= '0; h_hdop <= '0; h_lat <= '0; h_lon <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        h_hour <= n_hour; h_min <= n_min; h_sec <= n_sec; h_ms <= n_ms;
        h_sats <= n_sats; h_hdop <= n_hdop; h_lat <= n_lat; h_lon <= n_lon;
      end
      if (adv && e5.emt) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && e5.emt)
      m_tdata <= {7'd0, n_hdop, n_sats, e5.west, n_lon, e5.south, n_lat,
                  n_ms, n_sec, n_min, n_hour, e5.fix, e5.ok};
  end

endmodule

// ===== tb/nmea_gga_sentence_parser_tb.sv =====
// ---------------------------------------------------------------------------
// nmea_gga_sentence_parser_tb
// Self-checking bench for the GGA sentence decoder: byte stream in, one
// decoded record per line feed out, compared against an in-bench model.
// ---------------------------------------------------------------------------

// Decode state and expected-record queue for the sentence parser.
class gga_scoreboard;
  bit          active;
  int unsigned body_len;
  bit [7:0]    csum_calc;
  bit          hdr_ok;
  int unsigned fld;
  int unsigned star_ph;
  bit [7:0]    csum_rx;
  bit          hex_bad;
  int unsigned ipart;
  int unsigned fpart;
  int unsigned fdig;
  // held values of the sentence being decoded
  bit [6:0]    hh, mm, ss;
  bit [9:0]    ms;
  bit [26:0]   lat;
  bit [29:0]   lon;
  bit          south, west, fix;
  bit [6:0]    sats;
  bit [13:0]   hdop;
  bit [119:0]  pending[$];
  int          errors;
  int          seen;

  function void clear_sentence();
    body_len = 0; csum_calc = 0; hdr_ok = 1; fld = 0; star_ph = 0;
    csum_rx = 0; hex_bad = 0; ipart = 0; fpart = 0; fdig = 0;
    hh = 0; mm = 0; ss = 0; ms = 0; lat = 0; lon = 0;
    south = 0; west = 0; fix = 0; sats = 0; hdop = 0;
  endfunction

  function new();
    active = 0;
    errors = 0;
    seen = 0;
    clear_sentence();
  endfunction

  // fraction padded out to MIN_FRAC_DIGITS digits
  function int unsigned frac_scaled();
    int unsigned kept, s;
    kept = (fdig != 0) ? fdig - 1 : 0;
    if (kept > nmgga_pkg::MIN_FRAC_DIGITS) kept = nmgga_pkg::MIN_FRAC_DIGITS;
    s = fpart;
    repeat (nmgga_pkg::MIN_FRAC_DIGITS - kept) s = s * 10;
    return s;
  endfunction

  function longint unsigned microdeg(int unsigned w, int unsigned f, longint unsigned lim);
    longint unsigned sc, mins, v;
    sc = 100000;
    mins = longint'(w % 100) * sc + f;
    v = longint'(w / 100) * 1000000 + mins * 1000000 / (60 * sc);
    return (v > lim) ? lim : v;
  endfunction

  function void close_field();
    int unsigned f, w;
    longint unsigned h;
    f = frac_scaled();
    w = ipart;
    case (fld)
      nmgga_pkg::FLD_TIME: begin
        hh = 7'(w / 10000); mm = 7'((w / 100) % 100); ss = 7'(w % 100);
        ms = 10'(f / 100);
      end
      nmgga_pkg::FLD_LAT: lat = 27'(microdeg(w, f, 99999999));
      nmgga_pkg::FLD_LON: lon = 30'(microdeg(w, f, 999999999));
      nmgga_pkg::FLD_SATS: sats = 7'((w > 99) ? 99 : w);
      nmgga_pkg::FLD_HDOP: begin
        h = longint'(w) * 100 + f / 1000;
        hdop = 14'((h > 9999) ? 9999 : h);
      end
      default: ;
    endcase
    if (fld < 15) fld++;
    ipart = 0; fpart = 0; fdig = 0;
  endfunction

  function void field_byte(bit [7:0] c);
    int unsigned v;
    if (fld == nmgga_pkg::FLD_NS || fld == nmgga_pkg::FLD_EW ||
        fld == nmgga_pkg::FLD_FIX) begin
      if (ipart == 0) begin
        ipart = 1;
        if (fld == nmgga_pkg::FLD_FIX) fix = (c >= nmgga_pkg::CH_1);
        else if (fld == nmgga_pkg::FLD_NS) south = (c == nmgga_pkg::CH_US);
        else west = (c == nmgga_pkg::CH_UW);
      end
      return;
    end
    if (c >= nmgga_pkg::CH_0 && c <= nmgga_pkg::CH_9) begin
      if (fdig == 0) begin
        v = ipart * 10 + (c - nmgga_pkg::CH_0);
        ipart = (v > 999999) ? 999999 : v;
      end else if (fdig - 1 < nmgga_pkg::MIN_FRAC_DIGITS) begin
        fpart = fpart * 10 + (c - nmgga_pkg::CH_0);
        fdig++;
      end
    end else if (c == nmgga_pkg::CH_DOT && fdig == 0) begin
      fdig = 1;
    end
  endfunction

  // accepted input byte
  function void note_byte(bit [7:0] c);
    int unsigned pos;
    bit ok;
    bit [119:0] r;
    bit [3:0] nib;
    if (c == nmgga_pkg::CH_DOLLAR) begin
      clear_sentence();
      active = 1;
      return;
    end
    if (!active) return;
    if (body_len >= nmgga_pkg::MAX_LEN) begin
      active = 0;
      return;
    end
    pos = body_len;
    body_len++;
    if (c == nmgga_pkg::CH_LF) begin
      if (star_ph == 0) close_field();
      ok = hdr_ok && pos >= 5 && star_ph == 3 && !hex_bad && csum_rx == csum_calc;
      r = '0;
      r[0] = ok; r[1] = ok & fix; r[8:2] = hh; r[15:9] = mm; r[22:16] = ss;
      r[32:23] = ms; r[59:33] = lat; r[60] = south; r[90:61] = lon;
      r[91] = west; r[98:92] = sats; r[112:99] = hdop;
      pending.push_back(r);
      active = 0;
      return;
    end
    if (pos < nmgga_pkg::HDR_LEN && c != nmgga_pkg::hdr_char(3'(pos))) hdr_ok = 0;
    if (star_ph == 0) begin
      if (c == nmgga_pkg::CH_STAR) begin
        close_field();
        star_ph = 1;
      end else begin
        csum_calc ^= c;
        if (c == nmgga_pkg::CH_COMMA) close_field();
        else field_byte(c);
      end
    end else if (star_ph < 3) begin
      nib = 0;
      if (c >= nmgga_pkg::CH_0 && c <= nmgga_pkg::CH_9) nib = 4'(c - nmgga_pkg::CH_0);
      else if (c >= nmgga_pkg::CH_UA && c <= nmgga_pkg::CH_UF) nib = 4'(c - 8'h37);
      else hex_bad = 1;
      csum_rx = {csum_rx[3:0], nib};
      star_ph++;
    end
  endfunction

  function void check_record(bit [119:0] got);
    bit [119:0] want;
    seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected record %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got[0] !== want[0])
      $display("%0t: sentence_ok exp %0d got %0d", $time, want[0], got[0]);
    if (got[1] !== want[1])
      $display("%0t: fix_valid exp %0d got %0d", $time, want[1], got[1]);
    if (got[8:2] !== want[8:2])
      $display("%0t: utc_hour exp %0d got %0d", $time, want[8:2], got[8:2]);
    if (got[15:9] !== want[15:9])
      $display("%0t: utc_minute exp %0d got %0d", $time, want[15:9], got[15:9]);
    if (got[22:16] !== want[22:16])
      $display("%0t: utc_second exp %0d got %0d", $time, want[22:16], got[22:16]);
    if (got[32:23] !== want[32:23])
      $display("%0t: utc_millis exp %0d got %0d", $time, want[32:23], got[32:23]);
    if (got[59:33] !== want[59:33])
      $display("%0t: lat_microdeg exp %0d got %0d", $time, want[59:33], got[59:33]);
    if (got[60] !== want[60])
      $display("%0t: lat_south exp %0d got %0d", $time, want[60], got[60]);
    if (got[90:61] !== want[90:61])
      $display("%0t: lon_microdeg exp %0d got %0d", $time, want[90:61], got[90:61]);
    if (got[91] !== want[91])
      $display("%0t: lon_west exp %0d got %0d", $time, want[91], got[91]);
    if (got[98:92] !== want[98:92])
      $display("%0t: satellites exp %0d got %0d", $time, want[98:92], got[98:92]);
    if (got[112:99] !== want[112:99])
      $display("%0t: hdop_centi exp %0d got %0d", $time, want[112:99], got[112:99]);
    if (got[119:113] !== want[119:113])
      $display("%0t: pad bits exp %h got %h", $time, want[119:113], got[119:113]);
    if (got !== want) errors++;
  endfunction
endclass

module nmea_gga_sentence_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;     // [7:0] rx_byte
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;     // decoded record, layout as in the DUT port list

  gga_scoreboard sb;
  bit [7:0] tx_bytes[$];     // bytes waiting to be sent
  bit       calm;            // no idling in the final stretch
  bit       hold_sink;       // long receiver hold-off request
  int       idle_cycles;

  nmea_gga_sentence_parser u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Sentence builders
  // ---------------------------------------------------------------------
  function automatic string digits(int n, int len);
    string s;
    s = "";
    repeat (len) begin
      s = {string'(8'(48 + n % 10)), s};
      n = n / 10;
    end
    return s;
  endfunction

  function automatic string hex2(bit [7:0] v);
    string h;
    h = "0123456789ABCDEF";
    return {string'(h[v[7:4]]), string'(h[v[3:0]])};
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endfunction

  // "$body*CS\n" with checksum either right or forced
  function automatic void queue_sentence(string body, bit good_cs, string tail);
    bit [7:0] x;
    x = 0;
    for (int i = 0; i < body.len(); i++) x ^= body[i];
    if (!good_cs) x ^= 8'(1 + $urandom_range(0, 254));
    queue_text({"$", body, "*", hex2(x), tail, "\n"});
  endfunction

  function automatic string rand_number(int ilen, int flen);
    string s;
    s = digits($urandom_range(0, 9999999), ilen);
    if (flen >= 0) s = {s, ".", digits($urandom_range(0, 9999999), flen)};
    return s;
  endfunction

  // well-formed GGA body with random content
  function automatic string rand_gga();
    string hdr, b;
    hdr = ($urandom_range(0, 9) == 0) ? "GPGGA" : "GNGGA";
    b = {hdr, ",", rand_number($urandom_range(0, 7), $urandom_range(0, 4) - 1)};
    b = {b, ",", rand_number($urandom_range(0, 5), $urandom_range(0, 7) - 1)};
    b = {b, ",", ($urandom_range(0, 1) ? "S" : "N")};
    b = {b, ",", rand_number($urandom_range(0, 6), $urandom_range(0, 7) - 1)};
    b = {b, ",", ($urandom_range(0, 1) ? "W" : "E")};
    b = {b, ",", digits($urandom_range(0, 8), 1)};
    b = {b, ",", digits($urandom_range(0, 150), $urandom_range(0, 3))};
    b = {b, ",", rand_number($urandom_range(0, 4), $urandom_range(0, 4) - 1)};
    if ($urandom_range(0, 1)) b = {b, ",545.4,M,46.9,M,,"};
    return b;
  endfunction

  function automatic string rand_noise(int n);
    string s;
    s = "";
    repeat (n) s = {s, string'(8'($urandom_range(1, 255)))};
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic send_all();
    int gap;
    while (tx_bytes.size() != 0) begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= tx_bytes.pop_front();
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // monitors: inputs update the model, outputs are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_record(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    calm = 0;
    hold_sink = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reference sentence, extremes, special cases
    queue_text("garbage before start,*12\n");
    queue_sentence("GNGGA,235959.999,8959.99999,S,17959.99999,W,9,99,99.99", 1, "");
    queue_sentence("GNGGA,000000,0000.00000,N,00000.00000,E,0,00,0.0", 1, "");
    queue_sentence("GNGGA,,,,,,,,,,,,,", 1, "");
    queue_sentence("GNGGA,123456.7,9999.99999,N,99999.999999,E,1,150,9999999.9", 1, "");
    queue_sentence("GNGGA,12x3.4.5,4807.038,N,01131.000,E,1,08,0.9,545.4,M", 0, "");
    queue_sentence("GPGGA,1,2,N,3,E,1,4,5", 1, "");
    queue_sentence("GNG", 1, "");
    queue_text("$GN\n");
    queue_text("$GNGGA,1,2,N,3,E,1,4,5\n");
    queue_text("$GNGGA,1,2*\n");
    queue_text("$GNGGA,1,2*a1\n");
    queue_text("$GNGGA,1,2*3\n");
    queue_text("$GNGGA,1,2*3G\n");
    queue_sentence("GNGGA,1,2,N", 1, "ZZ");
    queue_text({"$GNGGA,", rand_noise(0), "0"});
    for (int i = 0; i < 140; i++) queue_text("1");
    queue_text("\n");
    queue_text({"$GNGGA,", digits(1, 115), "*00\n"});
    queue_text("$GNGGA,1$GNGGA,2*00\n");
    queue_text("$GNGGA,0,0,N,0,E,0,0,0*2F\n");
    // hex A-F checksum digits
    queue_sentence("GNGGA,9,9,S,9,W,3,1,1.5", 1, "");
    fork
      send_all();
      begin
        repeat (100) @(posedge clk);
        hold_sink = 1;
      end
    join

    // random: mostly well-formed sentences, some noise and broken ones
    while (!calm || tx_bytes.size() < 240) begin
      case ($urandom_range(0, 9))
        0: queue_text(rand_noise($urandom_range(1, 20)));
        1: queue_text({"$", rand_noise($urandom_range(0, 30)), "\n"});
        2: queue_sentence(rand_gga(), 0, "");
        default: queue_sentence(rand_gga(), 1, "");
      endcase
      if (tx_bytes.size() > 280 && !calm) begin
        send_all();
        calm = 1;
      end
    end
    // every byte value except '$' through the noise path
    for (int v = 0; v < 256; v++) if (v != 36) tx_bytes.push_back(8'(v));
    queue_sentence(rand_gga(), 1, "");
    send_all();

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
